// ----- src/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Phase codes, header constants and defaults shared by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

	// default width of the payload length counter
	localparam int unsigned LEN_BITS_DEFAULT = 64;

	// second header byte length codes
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// header byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

endpackage

`default_nettype wire

// ----- src/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Byte-serial receive-side frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// A result word is registered and is on the output in the cycle after the
// input word that causes it is accepted.
// Throughput: one input word per cycle; the output register is the only
// storage between the two sides, so a stalled output stalls the input.
// Reset: arst_n clears the parser to the first header byte and all parser state and the result valid flag to 0.
`default_nettype none

module websocket_frame_deframer_unit
	import wsfd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LEN_BITS_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] stream_byte,
	// output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            has_byte,
	output logic [3:0]      message_opcode,
	output logic            message_start,
	output logic            message_end
);

	// ------------------------------------------------------------------------
	// Parser state
	// ------------------------------------------------------------------------
	phase_t                   phase_q,     phase_nxt;
	logic                     final_q,     final_nxt;
	logic                     masked_q,    masked_nxt;
	logic [3:0]               opcode_q,    opcode_nxt;
	logic [3:0]               hdr_cnt_q,   hdr_cnt_nxt;
	logic [LENGTH_BITS-1:0]   rem_q,       rem_nxt;
	logic [31:0]              mask_key_q,  mask_key_nxt;
	logic [1:0]               mask_pos_q,  mask_pos_nxt;
	logic                     start_pend_q, start_pend_nxt;

	// result register
	logic                     out_valid_q;
	logic [7:0]               payload_byte_q;
	logic                     has_byte_q;
	logic [3:0]               opcode_out_q;
	logic                     start_out_q;
	logic                     end_out_q;

	// result of the current word
	logic                     emit;
	logic [7:0]               emit_data;
	logic                     emit_has;
	logic                     emit_end;

	logic                     accept;
	logic                     hdr_done;   // header complete on this word
	logic [7:0]               key_byte;
	logic                     last_byte;

	// A word is taken whenever the result register is free or drains now.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Mask key byte for this payload position, most significant byte first
	always_comb begin
		case (mask_pos_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	assign last_byte = (rem_q[LENGTH_BITS-1:1] == '0);

	// ------------------------------------------------------------------------
	// Next state and result
	// ------------------------------------------------------------------------
	always_comb begin
		phase_nxt      = phase_q;
		final_nxt      = final_q;
		masked_nxt     = masked_q;
		opcode_nxt     = opcode_q;
		hdr_cnt_nxt    = hdr_cnt_q;
		rem_nxt        = rem_q;
		mask_key_nxt   = mask_key_q;
		mask_pos_nxt   = mask_pos_q;
		start_pend_nxt = start_pend_q;
		hdr_done       = 1'b0;
		emit           = 1'b0;
		emit_data      = 8'd0;
		emit_has       = 1'b0;
		emit_end       = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				final_nxt = stream_byte[7];
				if (stream_byte[3:0] != 4'd0) begin
					opcode_nxt     = stream_byte[3:0];
					start_pend_nxt = 1'b1;
				end
				phase_nxt = PH_HDR1;
			end
			PH_HDR1: begin
				masked_nxt = stream_byte[7];
				rem_nxt    = '0;
				if (stream_byte[6:0] == LEN7_EXT16) begin
					hdr_cnt_nxt = EXT16_BYTES;
					phase_nxt   = PH_EXTLEN;
				end else if (stream_byte[6:0] == LEN7_EXT64) begin
					hdr_cnt_nxt = EXT64_BYTES;
					phase_nxt   = PH_EXTLEN;
				end else begin
					rem_nxt = {{(LENGTH_BITS-7){1'b0}}, stream_byte[6:0]};
					// length complete: on to the mask key or the payload
					mask_key_nxt = '0;
					if (stream_byte[7]) begin
						phase_nxt   = PH_MASK;
						hdr_cnt_nxt = MASK_BYTES;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				// saturate lengths that overflow the counter
				if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0)
					rem_nxt = '1;
				else
					rem_nxt = {rem_q[LENGTH_BITS-9:0], stream_byte};
				hdr_cnt_nxt = hdr_cnt_q - 4'd1;
				if (hdr_cnt_nxt == 4'd0) begin
					mask_key_nxt = '0;
					if (masked_q) begin
						phase_nxt   = PH_MASK;
						hdr_cnt_nxt = MASK_BYTES;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_MASK: begin
				mask_key_nxt = {mask_key_q[23:0], stream_byte};
				hdr_cnt_nxt  = hdr_cnt_q - 4'd1;
				if (hdr_cnt_nxt == 4'd0)
					hdr_done = 1'b1;
			end
			PH_PAYLOAD: begin
				emit         = 1'b1;
				emit_data    = stream_byte ^ key_byte;
				emit_has     = 1'b1;
				emit_end     = last_byte & final_q;
				mask_pos_nxt = mask_pos_q + 2'd1;
				if (last_byte) begin
					rem_nxt   = '0;
					phase_nxt = PH_HDR0;
				end else begin
					rem_nxt = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
				end
			end
			default: begin
				phase_nxt = PH_HDR0;
			end
		endcase

		// header finished: payload follows, or an empty frame closes here
		if (hdr_done) begin
			mask_pos_nxt = 2'd0;
			if (rem_nxt != '0) begin
				phase_nxt = PH_PAYLOAD;
			end else begin
				phase_nxt = PH_HDR0;
				if (final_q) begin
					emit     = 1'b1;
					emit_end = 1'b1;
				end
			end
		end

		if (emit)
			start_pend_nxt = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			final_q      <= 1'b0;
			masked_q     <= 1'b0;
			opcode_q     <= 4'd0;
			hdr_cnt_q    <= 4'd0;
			rem_q        <= '0;
			mask_key_q   <= '0;
			mask_pos_q   <= 2'd0;
			start_pend_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_nxt;
			final_q      <= final_nxt;
			masked_q     <= masked_nxt;
			opcode_q     <= opcode_nxt;
			hdr_cnt_q    <= hdr_cnt_nxt;
			rem_q        <= rem_nxt;
			mask_key_q   <= mask_key_nxt;
			mask_pos_q   <= mask_pos_nxt;
			start_pend_q <= start_pend_nxt;
		end
	end

	// result valid: set by a new result, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload; opcode and start come from the state before this word
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			payload_byte_q <= emit_data;
			has_byte_q     <= emit_has;
			opcode_out_q   <= opcode_q;
			start_out_q    <= start_pend_q;
			end_out_q      <= emit_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload_byte   = payload_byte_q;
	assign has_byte       = has_byte_q;
	assign message_opcode = opcode_out_q;
	assign message_start  = start_out_q;
	assign message_end    = end_out_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXTLEN || phase_q == PH_MASK) |-> hdr_cnt_q != 4'd0)
		else $error("header byte count empty inside extended length or mask");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with nothing remaining");

	a_pos_start: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD && $past(phase_q) != PH_PAYLOAD) |-> mask_pos_q == 2'd0)
		else $error("mask position not reset at payload start");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && !emit_has) |=> out_valid_q && message_end && !has_byte)
		else $error("empty result does not close the message");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives framed byte streams (short, 16-bit and 64-bit lengths, masked and
// bare, fragmented, control and reserved opcodes, cut-off frames and noise)
// into the deframer under random sender idling and receiver stalls, and checks
// every result word against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import wsfd_pkg::*;

	localparam int unsigned LEN_W = LEN_BITS_DEFAULT;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// cycles with neither side moving a word before the run is abandoned
	localparam int unsigned STALL_LIMIT = 2000;
	// cycles still waited at the end once no result word is expected
	localparam int unsigned DRAIN_CYCLES = 10;
	// stream words per idling phase of the random part
	localparam int unsigned PHASE_WORDS = 175;

	// opcodes used to build frames
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic [3:0] opcode;
		logic       start;
		logic       last;
	} payload_word_t;

	// Parser model plus the queue of result words it has predicted.
	class deframe_checker;
		phase_t          phase = PH_HDR0;
		bit              fin;
		bit              masked;
		logic [3:0]      opcode = '0;
		logic [3:0]      hdr_left = '0;
		logic [LEN_W-1:0] remaining = '0;
		logic [31:0]     key = '0;
		logic [1:0]      key_pos = '0;
		bit              start_due;
		payload_word_t   due_words[$];
		int unsigned     mismatches, bytes_taken, words_checked, ends_seen, empty_ends;

		function void push_word(logic [7:0] data, logic has, logic last);
			due_words.push_back('{data, has, opcode, start_due, last});
			start_due = 0;
		endfunction

		function void close_header();
			key_pos = '0;
			if (remaining != 0) begin
				phase = PH_PAYLOAD;
			end else begin
				phase = PH_HDR0;
				if (fin)
					push_word(8'h00, 1'b0, 1'b1);
			end
		endfunction

		function void close_length();
			key = '0;
			if (masked) begin
				phase = PH_MASK;
				hdr_left = MASK_BYTES;
			end else begin
				close_header();
			end
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] kb;
			logic last;
			bytes_taken++;
			case (phase)
				PH_HDR0: begin
					fin = b[7];
					if (b[3:0] != OP_CONT) begin
						opcode = b[3:0];
						start_due = 1;
					end
					phase = PH_HDR1;
				end
				PH_HDR1: begin
					masked = b[7];
					remaining = '0;
					if (b[6:0] == LEN7_EXT16) begin
						hdr_left = EXT16_BYTES;
						phase = PH_EXTLEN;
					end else if (b[6:0] == LEN7_EXT64) begin
						hdr_left = EXT64_BYTES;
						phase = PH_EXTLEN;
					end else begin
						remaining = LEN_W'(b[6:0]);
						close_length();
					end
				end
				PH_EXTLEN: begin
					// saturate rather than wrap when the length outgrows the counter
					if (remaining > (LEN_MAX >> 8))
						remaining = LEN_MAX;
					else
						remaining = {remaining[LEN_W-9:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 0)
						close_length();
				end
				PH_MASK: begin
					key = {key[23:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 0)
						close_header();
				end
				PH_PAYLOAD: begin
					kb = 8'(key >> (8 * (3 - int'(key_pos))));
					last = (remaining <= 1);
					push_word(b ^ kb, 1'b1, last & fin);
					key_pos = key_pos + 2'd1;
					remaining = last ? '0 : remaining - 1;
					if (last)
						phase = PH_HDR0;
				end
				default: phase = PH_HDR0;
			endcase
		endfunction

		task report(string why, payload_word_t got, payload_word_t want);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch (%s): got %h/%b/%h/%b/%b want %h/%b/%h/%b/%b", why,
					got.data, got.has, got.opcode, got.start, got.last,
					want.data, want.has, want.opcode, want.start, want.last);
		endtask

		task match_word(payload_word_t got);
			payload_word_t want;
			words_checked++;
			if (got.last)
				ends_seen++;
			if (got.last && !got.has)
				empty_ends++;
			if (due_words.size() == 0) begin
				report("word with nothing expected", got, '0);
			end else begin
				want = due_words.pop_front();
				if (got.data !== want.data || got.has !== want.has ||
						got.opcode !== want.opcode || got.start !== want.start ||
						got.last !== want.last)
					report("field differs", got, want);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] stream_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic [3:0] message_opcode;
	logic       message_start;
	logic       message_end;

	deframe_checker sb = new;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned frames_sent = 0;
	int unsigned frames_cut = 0;
	int unsigned quiet_cycles = 0;

	websocket_frame_deframer_unit #(
		.LENGTH_BITS(LEN_W)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.has_byte      (has_byte),
		.message_opcode(message_opcode),
		.message_start (message_start),
		.message_end   (message_end)
	);

	// 10-unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side: random stalls, changed on the falling edge only.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Result monitor: every word taken at a rising edge goes to the checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_word({payload_byte, has_byte, message_opcode, message_start, message_end});
	end

	// Watchdog: counts edges at which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Offers one stream word, idling first at random, and waits until the
	// deframer takes it. The model is updated at the accepting edge, so its
	// parse state is current whenever the next word is chosen.
	task automatic feed_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
	endtask

	// Builds one frame and sends it; a cut frame stops after a random prefix.
	// Payloads are capped, which only matters for the saturated length.
	task automatic send_frame(input bit fin, input logic [2:0] rsv, input logic [3:0] op,
			input bit masked, input longint unsigned len, input len_form_t form,
			input bit cut);
		logic [7:0] frame_bytes[$];
		int unsigned keep;
		frame_bytes.push_back({fin, rsv, op});
		case (form)
			FORM_EXT16: begin
				frame_bytes.push_back({masked, LEN7_EXT16});
				frame_bytes.push_back(8'(len >> 8));
				frame_bytes.push_back(8'(len));
			end
			FORM_EXT64: begin
				frame_bytes.push_back({masked, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					frame_bytes.push_back(8'(len >> (8 * i)));
			end
			default: frame_bytes.push_back({masked, 7'(len)});
		endcase
		if (masked)
			repeat (MASK_BYTES) frame_bytes.push_back(8'($urandom));
		for (longint unsigned i = 0; i < len && i < 130; i++)
			frame_bytes.push_back(8'($urandom));
		keep = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
		for (int unsigned i = 0; i < keep; i++)
			feed_byte(frame_bytes[i]);
		frames_sent++;
	endtask

	// A word that keeps the parser away from huge lengths, whatever phase it
	// is in: short length codes and small extended lengths only.
	function automatic logic [7:0] filler_byte();
		int unsigned pick;
		case (sb.phase)
			PH_HDR1: begin
				pick = $urandom_range(15);
				if (pick < 13)
					return {1'($urandom_range(1)), 7'(pick)};
				return {1'($urandom_range(1)), (pick == 13) ? LEN7_EXT16 : LEN7_EXT64};
			end
			PH_EXTLEN: return (sb.hdr_left == 1) ? 8'($urandom_range(15)) : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_frame(input bit cut);
		logic [3:0] op;
		logic [2:0] rsv;
		int unsigned sel;
		case ($urandom_range(9))
			0, 1, 2, 3: op = OP_CONT;
			4, 5: op = OP_TEXT;
			6, 7: op = OP_BINARY;
			8: op = OP_CLOSE + 4'($urandom_range(2)); // close, ping, pong
			default: op = 4'($urandom_range(15));
		endcase
		rsv = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b000;
		sel = $urandom_range(59);
		// mostly short payloads; the odd 125-byte one and extended forms
		if (sel < 40)
			send_frame($urandom_range(3) != 0, rsv, op, $urandom_range(3) != 0,
				$urandom_range(10), FORM_SHORT, cut);
		else if (sel < 48)
			send_frame($urandom_range(3) != 0, rsv, op, $urandom_range(3) != 0,
				$urandom_range(20), FORM_EXT16, cut);
		else if (sel < 56)
			send_frame($urandom_range(3) != 0, rsv, op, $urandom_range(3) != 0,
				$urandom_range(20), FORM_EXT64, cut);
		else
			send_frame($urandom_range(3) != 0, rsv, op, $urandom_range(3) != 0,
				(sel == 56) ? 125 : 0, FORM_SHORT, cut);
		if (cut) begin
			frames_cut++;
			// a little noise, then words chosen to bring the parser back to a header
			repeat ($urandom_range(3)) feed_byte(filler_byte());
			while (sb.phase != PH_HDR0)
				feed_byte(filler_byte());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling.
		// continuation with no message open: opcode stays 0, no start flag
		send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 1, FORM_SHORT, 1'b0);
		// masked text word with all reserved bits set
		send_frame(1'b1, 3'b111, OP_TEXT, 1'b1, 1, FORM_SHORT, 1'b0);
		// empty final frame: one word with no data closes the message
		send_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 0, FORM_SHORT, 1'b0);
		// empty non-final frame in 16-bit form: start must carry over
		send_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 0, FORM_EXT16, 1'b0);
		// final continuation in 64-bit form picks up the carried start
		send_frame(1'b1, 3'b000, OP_CONT, 1'b0, 1, FORM_EXT64, 1'b0);

		// Random part in three idling regimes.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 26 : (p == 1) ? 64 : 0;
			recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 26 : 0;
			while (sb.bytes_taken < 27 + PHASE_WORDS * (p + 1))
				random_frame($urandom_range(99) < 15);
		end

		// all-ones 64-bit length: the counter saturates and never runs out,
		// so this frame has to come last
		send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, FORM_EXT64, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d stream words in %0d frames (%0d cut short)",
			sb.bytes_taken, frames_sent, frames_cut);
		$display("checked %0d result words, %0d message ends, %0d of them empty",
			sb.words_checked, sb.ends_seen, sb.empty_ends);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- websocket_frame_deframer_unit.f -----
src/wsfd_pkg.sv
src/websocket_frame_deframer_unit.sv
test/testbench.sv
